// ===== src/depth_pixel_to_world_point_core_assert.svh =====
// ----------------------------------------------------------------------------
// depth pixel to world point assertion macros
// shared concurrent assertion forms for the back-projection core
// ----------------------------------------------------------------------------
`ifndef DEPTH_PIXEL_TO_WORLD_POINT_CORE_ASSERT_SVH
`define DEPTH_PIXEL_TO_WORLD_POINT_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define DPWP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define DPWP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dpwp_pkg.sv =====
// ----------------------------------------------------------------------------
// depth pixel to world point package
// register indexes, reset values, port widths and fixed-point limits
// ----------------------------------------------------------------------------
package dpwp_pkg;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 63;

    localparam logic [CFG_ADDR_W-1:0] REG_OPTICAL_CENTER  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_INV_FOCAL       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_INV_DEPTH_SCALE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ROTATION_ROW_X  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ROTATION_ROW_Y  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_ROTATION_ROW_Z  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_TRANSLATION     = 3'd6;

    // register reset values
    localparam logic [25:0] OPTICAL_CENTER_RST  = 26'd4153995;
    localparam logic [47:0] INV_FOCAL_RST       = 48'd542340316804;
    localparam logic [31:0] INV_DEPTH_SCALE_RST = 32'd4294967;
    localparam logic [59:0] ROTATION_ROW_X_RST  = 60'd262144;
    localparam logic [59:0] ROTATION_ROW_Y_RST  = 60'd274877906944;
    localparam logic [59:0] ROTATION_ROW_Z_RST  = 60'd288230376151711744;
    localparam logic [62:0] TRANSLATION_RST     = 63'd0;

    // stream widths
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 120;

    // pipeline depth, last stage is the output register
    localparam int PIPE_STAGES = 8;

    // camera coordinate clamp, +-(2^41 - 1) in Q.16
    localparam logic signed [46:0] CAM_HI = 47'sd2199023255551;
    localparam logic signed [46:0] CAM_LO = -47'sd2199023255551;

    // world coordinate saturation bounds
    localparam logic signed [45:0] WORLD_HI = 46'sd2147483647;
    localparam logic signed [45:0] WORLD_LO = -46'sd2147483648;

    // colour carried alongside the point
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } col_t;

endpackage

// ===== src/depth_pixel_to_world_point_core.sv =====
// ----------------------------------------------------------------------------
// depth pixel to world point core
// back-projects RGB-D pixels into saturated Q16.16 world points with colour
// ----------------------------------------------------------------------------
// One pixel word is taken per clock while s_axis_tready is high; the eight
// register stages (depth and focal products, rounding, camera x/y products,
// clamping, rotation partial products, two adder levels, output saturation)
// each hold their own valid bit, so a stall at the output only backs up as
// far as the first empty stage and bubbles are squeezed out. Pixels with zero
// depth are dropped at the input and produce no point. The pose and intrinsics
// are plain registers, written through the config port, with no clearing pass
// after reset; the user must write them with no pixel in flight (not checked).

`include "depth_pixel_to_world_point_core_assert.svh"

module depth_pixel_to_world_point_core
    import dpwp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // pixel words in
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // column, row, depth, blue_in, green_in, red_in
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // point words out
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // world_x, world_y, world_z, red_out, green_out, blue_out
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int LAST = PIPE_STAGES - 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [25:0] optical_center_reg;
    logic [47:0] inv_focal_reg;
    logic [31:0] inv_depth_scale_reg;
    logic [59:0] rot_row_reg [3];
    logic [62:0] translation_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            optical_center_reg  <= OPTICAL_CENTER_RST;
            inv_focal_reg       <= INV_FOCAL_RST;
            inv_depth_scale_reg <= INV_DEPTH_SCALE_RST;
            rot_row_reg[0]      <= ROTATION_ROW_X_RST;
            rot_row_reg[1]      <= ROTATION_ROW_Y_RST;
            rot_row_reg[2]      <= ROTATION_ROW_Z_RST;
            translation_reg     <= TRANSLATION_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_OPTICAL_CENTER:  optical_center_reg  <= cfg_wdata[25:0];
                REG_INV_FOCAL:       inv_focal_reg       <= cfg_wdata[47:0];
                REG_INV_DEPTH_SCALE: inv_depth_scale_reg <= cfg_wdata[31:0];
                REG_ROTATION_ROW_X:  rot_row_reg[0]      <= cfg_wdata[59:0];
                REG_ROTATION_ROW_Y:  rot_row_reg[1]      <= cfg_wdata[59:0];
                REG_ROTATION_ROW_Z:  rot_row_reg[2]      <= cfg_wdata[59:0];
                REG_TRANSLATION:     translation_reg     <= cfg_wdata[62:0];
                default:             ;
            endcase
        end
    end

    // register fields
    logic [12:0]        cx, cy;
    logic [23:0]        ifx, ify;
    logic signed [19:0] rot [3][3];
    logic signed [20:0] trans [3];

    always_comb
    begin
        cx  = optical_center_reg[12:0];
        cy  = optical_center_reg[25:13];
        ifx = inv_focal_reg[23:0];
        ify = inv_focal_reg[47:24];
        for (int r = 0; r < 3; r++)
        begin
            rot[r][0] = rot_row_reg[r][19:0];
            rot[r][1] = rot_row_reg[r][39:20];
            rot[r][2] = rot_row_reg[r][59:40];
            trans[r]  = translation_reg[21*r +: 21];
        end
    end

    // ------------------------------------------------------------------
    // input word unpacking
    // ------------------------------------------------------------------
    logic [11:0] in_column, in_row;
    logic [15:0] in_depth;
    col_t        in_col;
    logic        in_acc;

    assign in_column    = s_axis_tdata[11:0];
    assign in_row       = s_axis_tdata[23:12];
    assign in_depth     = s_axis_tdata[39:24];
    assign in_col.blue  = s_axis_tdata[47:40];
    assign in_col.green = s_axis_tdata[55:48];
    assign in_col.red   = s_axis_tdata[63:56];
    assign in_acc       = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // stage valids and advance chain
    // ------------------------------------------------------------------
    logic [PIPE_STAGES-1:0] vld_reg, vld_next, adv;
    col_t                   col_reg [PIPE_STAGES];

    always_comb
    begin
        adv[LAST] = !vld_reg[LAST] || m_axis_tready;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        vld_next[0] = in_acc && (in_depth != 16'd0);
        for (int i = 1; i < PIPE_STAGES; i++)
        begin
            vld_next[i] = vld_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < PIPE_STAGES; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    // colour rides along every stage
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            col_reg[0] <= in_col;
        end
        for (int i = 1; i < PIPE_STAGES; i++)
        begin
            if (adv[i])
            begin
                col_reg[i] <= col_reg[i-1];
            end
        end
    end

    assign s_axis_tready = adv[0];

    // ------------------------------------------------------------------
    // stage 0: depth scale product and centred pixel times inverse focal
    // ------------------------------------------------------------------
    logic signed [13:0] du, dv;
    logic [47:0]        s0_pz_next, s0_pz_reg;
    logic signed [38:0] s0_pax_next, s0_pax_reg, s0_pay_next, s0_pay_reg;

    always_comb
    begin
        du = $signed({1'b0, in_column, 1'b0}) - $signed({1'b0, cx});
        dv = $signed({1'b0, in_row, 1'b0}) - $signed({1'b0, cy});
        s0_pz_next  = 48'(in_depth) * 48'(inv_depth_scale_reg);
        s0_pax_next = du * $signed({1'b0, ifx});
        s0_pay_next = dv * $signed({1'b0, ify});
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s0_pz_reg  <= s0_pz_next;
            s0_pax_reg <= s0_pax_next;
            s0_pay_reg <= s0_pay_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: round z to Q16.16 and the angles to Q.16
    // ------------------------------------------------------------------
    logic [48:0]        zsum;
    logic signed [38:0] ax_sum, ay_sum;
    logic [31:0]        s1_z_next, s1_z_reg;
    logic signed [29:0] s1_ax_next, s1_ax_reg, s1_ay_next, s1_ay_reg;

    always_comb
    begin
        zsum       = {1'b0, s0_pz_reg} + 49'd32768;
        ax_sum     = s0_pax_reg + 39'sd256;
        ay_sum     = s0_pay_reg + 39'sd256;
        s1_z_next  = zsum[47:16];
        s1_ax_next = ax_sum[38:9];
        s1_ay_next = ay_sum[38:9];
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_z_reg  <= s1_z_next;
            s1_ax_reg <= s1_ax_next;
            s1_ay_reg <= s1_ay_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: camera x and y products
    // ------------------------------------------------------------------
    logic signed [62:0] s2_mx_next, s2_mx_reg, s2_my_next, s2_my_reg;
    logic [31:0]        s2_z_reg;

    always_comb
    begin
        s2_mx_next = s1_ax_reg * $signed({1'b0, s1_z_reg});
        s2_my_next = s1_ay_reg * $signed({1'b0, s1_z_reg});
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s2_mx_reg <= s2_mx_next;
            s2_my_reg <= s2_my_next;
            s2_z_reg  <= s1_z_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: round and clamp camera x and y to 42 bits
    // ------------------------------------------------------------------
    logic signed [62:0] mx_sum, my_sum;
    logic signed [46:0] rx, ry;
    logic signed [41:0] s3_x_next, s3_x_reg, s3_y_next, s3_y_reg;
    logic [31:0]        s3_z_reg;

    always_comb
    begin
        mx_sum = s2_mx_reg + 63'sd32768;
        my_sum = s2_my_reg + 63'sd32768;
        rx     = mx_sum[62:16];
        ry     = my_sum[62:16];
        if (rx > CAM_HI)
            s3_x_next = CAM_HI[41:0];
        else if (rx < CAM_LO)
            s3_x_next = CAM_LO[41:0];
        else
            s3_x_next = rx[41:0];
        if (ry > CAM_HI)
            s3_y_next = CAM_HI[41:0];
        else if (ry < CAM_LO)
            s3_y_next = CAM_LO[41:0];
        else
            s3_y_next = ry[41:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s3_x_reg <= s3_x_next;
            s3_y_reg <= s3_y_next;
            s3_z_reg <= s2_z_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: rotation partial products, x and y split in 21-bit halves
    // ------------------------------------------------------------------
    logic signed [41:0] s4_pxl_next [3], s4_pxl_reg [3];
    logic signed [40:0] s4_pxh_next [3], s4_pxh_reg [3];
    logic signed [41:0] s4_pyl_next [3], s4_pyl_reg [3];
    logic signed [40:0] s4_pyh_next [3], s4_pyh_reg [3];
    logic signed [52:0] s4_pzz_next [3], s4_pzz_reg [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            s4_pxl_next[r] = rot[r][0] * $signed({1'b0, s3_x_reg[20:0]});
            s4_pxh_next[r] = rot[r][0] * $signed(s3_x_reg[41:21]);
            s4_pyl_next[r] = rot[r][1] * $signed({1'b0, s3_y_reg[20:0]});
            s4_pyh_next[r] = rot[r][1] * $signed(s3_y_reg[41:21]);
            s4_pzz_next[r] = rot[r][2] * $signed({1'b0, s3_z_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s4_pxl_reg <= s4_pxl_next;
            s4_pxh_reg <= s4_pxh_next;
            s4_pyl_reg <= s4_pyl_next;
            s4_pyh_reg <= s4_pyh_next;
            s4_pzz_reg <= s4_pzz_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: join halves, add aligned translation and rounding half
    // ------------------------------------------------------------------
    logic signed [63:0] s5_sx_next [3], s5_sx_reg [3];
    logic signed [63:0] s5_sy_next [3], s5_sy_reg [3];
    logic signed [63:0] s5_szt_next [3], s5_szt_reg [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            s5_sx_next[r]  = (64'(s4_pxh_reg[r]) <<< 21) + 64'(s4_pxl_reg[r]);
            s5_sy_next[r]  = (64'(s4_pyh_reg[r]) <<< 21) + 64'(s4_pyl_reg[r]);
            s5_szt_next[r] = 64'(s4_pzz_reg[r]) + (64'(trans[r]) <<< 22)
                           + 64'sd131072;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s5_sx_reg  <= s5_sx_next;
            s5_sy_reg  <= s5_sy_next;
            s5_szt_reg <= s5_szt_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: full Q.34 accumulation per world axis
    // ------------------------------------------------------------------
    logic signed [63:0] s6_acc_next [3], s6_acc_reg [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            s6_acc_next[r] = s5_sx_reg[r] + s5_sy_reg[r] + s5_szt_reg[r];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            s6_acc_reg <= s6_acc_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 7: scale to Q16.16 and saturate, output register
    // ------------------------------------------------------------------
    logic signed [45:0] wfull [3];
    logic [31:0]        s7_w_next [3], s7_w_reg [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            wfull[r] = s6_acc_reg[r][63:18];
            if (wfull[r] > WORLD_HI)
                s7_w_next[r] = WORLD_HI[31:0];
            else if (wfull[r] < WORLD_LO)
                s7_w_next[r] = WORLD_LO[31:0];
            else
                s7_w_next[r] = wfull[r][31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[LAST])
        begin
            s7_w_reg <= s7_w_next;
        end
    end

    // output word packing
    assign m_axis_tvalid = vld_reg[LAST];
    assign m_axis_tdata  = {col_reg[LAST].blue, col_reg[LAST].green, col_reg[LAST].red,
                            s7_w_reg[2], s7_w_reg[1], s7_w_reg[0]};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `DPWP_ASSERT_NEXT(a_zero_depth_dropped, clk, rst_n,
        in_acc && (in_depth == 16'd0), !vld_reg[0],
        "zero-depth pixel entered the pipeline")
    `DPWP_ASSERT_NEXT(a_pixel_enters, clk, rst_n,
        in_acc && (in_depth != 16'd0), vld_reg[0],
        "accepted pixel missing from first stage")
    `DPWP_ASSERT_SAME(a_stall_only_when_full, clk, rst_n,
        !s_axis_tready, (&vld_reg) && !m_axis_tready,
        "input stalled while the pipeline has a bubble")
    `DPWP_ASSERT_NEXT(a_stage_handoff, clk, rst_n,
        vld_reg[LAST-1] && adv[LAST], vld_reg[LAST],
        "point lost between last two stages")

endmodule
